>>> hw/rtl/hdtc_pkg.sv
package hdtc_pkg;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  typedef enum logic [1:0] {
    POS_START,
    POS_ZERO,
    POS_BODY
  } pos_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_CONVERT,
    ST_PREFIX0,
    ST_PREFIXX,
    ST_SKIP,
    ST_EMIT,
    ST_STOP
  } state_e;

  typedef enum logic [2:0] {
    CNT_HOLD,
    CNT_DEC,
    CNT_BITS,
    CNT_NDIG,
    CNT_NHEX
  } cnt_op_e;

  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_ZERO,
    OUT_X,
    OUT_DIGIT
  } out_op_e;

  typedef struct packed {
    logic    accept;
    logic    tok_clear;
    logic    dig_clear;
    logic    hex_load;
    logic    dd_step;
    logic    dig_shift;
    cnt_op_e cnt_op;
    out_op_e out_op;
  } cmd_t;

  typedef struct packed {
    logic pos_start;
    logic is_minus;
    logic tok_end;
    logic hex_mode;
    logic cnt_one;
    logic top_zero;
    logic out_free;
  } sts_t;

  function automatic logic [7:0] digit_char(logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'h0, d};
    end else begin
      c = CH_UP_A + {4'h0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/hdtc_in_if.sv
interface hdtc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       token_end;

  modport source (output valid, ch, token_end, input ready);
  modport sink   (input valid, ch, token_end, output ready);
endinterface

>>> hw/rtl/hdtc_out_if.sv
interface hdtc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       out_last;

  modport source (output valid, out_char, out_last, input ready);
  modport sink   (input valid, out_char, out_last, output ready);
endinterface

>>> hw/rtl/hdtc_ctrl.sv
module hdtc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  hdtc_pkg::sts_t sts_i,
  output hdtc_pkg::cmd_t cmd_o
);
  import hdtc_pkg::*;

  state_e state_q, state_d;
  logic   fire;

  assign fire = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (fire) begin
          if (sts_i.pos_start && sts_i.is_minus) begin
            state_d = ST_STOP;
          end else if (sts_i.tok_end) begin
            state_d = ST_START;
          end
        end
      end
      ST_START: begin
        state_d = sts_i.hex_mode ? ST_CONVERT : ST_PREFIX0;
      end
      ST_CONVERT: begin
        if (sts_i.cnt_one) state_d = ST_SKIP;
      end
      ST_PREFIX0: begin
        if (sts_i.out_free) state_d = ST_PREFIXX;
      end
      ST_PREFIXX: begin
        if (sts_i.out_free) state_d = ST_SKIP;
      end
      ST_SKIP: begin
        if (!sts_i.top_zero || sts_i.cnt_one) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free && sts_i.cnt_one) state_d = ST_IDLE;
      end
      ST_STOP: begin
        state_d = ST_STOP;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i && !(sts_i.pos_start && sts_i.is_minus);
      end
      ST_START: begin
        cmd_o.tok_clear = 1'b1;
        if (sts_i.hex_mode) begin
          cmd_o.dig_clear = 1'b1;
          cmd_o.cnt_op    = CNT_BITS;
        end else begin
          cmd_o.hex_load = 1'b1;
          cmd_o.cnt_op   = CNT_NHEX;
        end
      end
      ST_CONVERT: begin
        cmd_o.dd_step = 1'b1;
        cmd_o.cnt_op  = sts_i.cnt_one ? CNT_NDIG : CNT_DEC;
      end
      ST_PREFIX0: begin
        if (sts_i.out_free) cmd_o.out_op = OUT_ZERO;
      end
      ST_PREFIXX: begin
        if (sts_i.out_free) cmd_o.out_op = OUT_X;
      end
      ST_SKIP: begin
        if (sts_i.top_zero && !sts_i.cnt_one) begin
          cmd_o.dig_shift = 1'b1;
          cmd_o.cnt_op    = CNT_DEC;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_op    = OUT_DIGIT;
          cmd_o.dig_shift = 1'b1;
          cmd_o.cnt_op    = CNT_DEC;
        end
      end
      ST_STOP: begin
        in_ready_o = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

>>> hw/rtl/hdtc_datapath.sv
module hdtc_datapath #(
  parameter int VALUE_BITS = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [7:0]     ch_i,
  input  logic           token_end_i,
  input  hdtc_pkg::cmd_t cmd_i,
  output hdtc_pkg::sts_t sts_o,
  hdtc_out_if.source     out_o
);
  import hdtc_pkg::*;

  localparam int NDIG = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int NHEX = (VALUE_BITS + 3) / 4;
  localparam int DW   = NDIG * 4;
  localparam int HW   = NHEX * 4;
  localparam int WW   = VALUE_BITS + 5;
  localparam int CW   = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] acc_q, acc_d;
  pos_e                  pos_q, pos_d;
  logic                  hex_q, hex_d;
  logic [DW-1:0]         dig_q, dig_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic                  ov_q, ov_d;
  logic [7:0]            oc_q, oc_d;
  logic                  ol_q, ol_d;

  logic                  is_dec, is_up, is_lo;
  logic [3:0]            dec_val, hex_val, dgt;
  logic [WW-1:0]         acc_w, mul, sum;
  logic [VALUE_BITS-1:0] pushed;
  logic [DW-1:0]         dig_adj;
  logic [3:0]            top;
  logic                  out_free;

  // digit decode and saturating multiply-add
  always_comb begin
    is_dec  = (ch_i >= CH_ZERO) && (ch_i <= CH_NINE);
    is_up   = (ch_i >= CH_UP_A) && (ch_i <= CH_UP_F);
    is_lo   = (ch_i >= CH_LO_A) && (ch_i <= CH_LO_F);
    dec_val = is_dec ? ch_i[3:0] : 4'd0;
    if (is_dec) begin
      hex_val = ch_i[3:0];
    end else if (is_up || is_lo) begin
      hex_val = ch_i[3:0] + 4'd9;
    end else begin
      hex_val = 4'd0;
    end
    acc_w  = WW'(acc_q);
    mul    = hex_q ? (acc_w << 4) : ((acc_w << 3) + (acc_w << 1));
    dgt    = hex_q ? hex_val : dec_val;
    sum    = mul + WW'(dgt);
    pushed = (|sum[WW-1:VALUE_BITS]) ? '1 : sum[VALUE_BITS-1:0];
  end

  // double dabble add-3 on every BCD digit
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      dig_adj[i*4 +: 4] = (dig_q[i*4 +: 4] >= 4'd5) ? dig_q[i*4 +: 4] + 4'd3
                                                     : dig_q[i*4 +: 4];
    end
  end

  assign top      = dig_q[DW-1 -: 4];
  assign out_free = !ov_q || out_o.ready;

  always_comb begin
    acc_d = acc_q;
    pos_d = pos_q;
    hex_d = hex_q;
    if (cmd_i.accept) begin
      unique case (pos_q)
        POS_START: begin
          acc_d = VALUE_BITS'(dec_val);
          pos_d = (ch_i == CH_ZERO) ? POS_ZERO : POS_BODY;
        end
        POS_ZERO: begin
          if (ch_i == CH_LO_X) begin
            hex_d = 1'b1;
            acc_d = '0;
          end else begin
            acc_d = pushed;
          end
          pos_d = POS_BODY;
        end
        POS_BODY: begin
          acc_d = pushed;
        end
        default: begin
          pos_d = POS_START;
        end
      endcase
    end else if (cmd_i.hex_load) begin
      acc_d = '0;
    end else if (cmd_i.dd_step) begin
      acc_d = acc_q << 1;
    end
    if (cmd_i.tok_clear) begin
      pos_d = POS_START;
      hex_d = 1'b0;
    end
  end

  always_comb begin
    dig_d = dig_q;
    if (cmd_i.dig_clear) begin
      dig_d = '0;
    end else if (cmd_i.hex_load) begin
      dig_d = '0;
      dig_d[DW-1 -: HW] = HW'(acc_q);
    end else if (cmd_i.dd_step) begin
      dig_d = {dig_adj[DW-2:0], acc_q[VALUE_BITS-1]};
    end else if (cmd_i.dig_shift) begin
      dig_d = dig_q << 4;
    end
  end

  always_comb begin
    unique case (cmd_i.cnt_op)
      CNT_DEC:  cnt_d = cnt_q - CW'(1);
      CNT_BITS: cnt_d = CW'(VALUE_BITS);
      CNT_NDIG: cnt_d = CW'(NDIG);
      CNT_NHEX: cnt_d = CW'(NHEX);
      default:  cnt_d = cnt_q;
    endcase
  end

  always_comb begin
    ov_d = ov_q;
    oc_d = oc_q;
    ol_d = ol_q;
    if (out_o.ready) ov_d = 1'b0;
    unique case (cmd_i.out_op)
      OUT_ZERO: begin
        ov_d = 1'b1;
        oc_d = CH_ZERO;
        ol_d = 1'b0;
      end
      OUT_X: begin
        ov_d = 1'b1;
        oc_d = CH_LO_X;
        ol_d = 1'b0;
      end
      OUT_DIGIT: begin
        ov_d = 1'b1;
        oc_d = digit_char(top);
        ol_d = (cnt_q == CW'(1));
      end
      default: begin
        oc_d = oc_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      pos_q <= POS_START;
      hex_q <= 1'b0;
      cnt_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      acc_q <= acc_d;
      pos_q <= pos_d;
      hex_q <= hex_d;
      cnt_q <= cnt_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q <= dig_d;
    oc_q  <= oc_d;
    ol_q  <= ol_d;
  end

  assign sts_o.pos_start = (pos_q == POS_START);
  assign sts_o.is_minus  = (ch_i == CH_MINUS);
  assign sts_o.tok_end   = token_end_i;
  assign sts_o.hex_mode  = hex_q;
  assign sts_o.cnt_one   = (cnt_q == CW'(1));
  assign sts_o.top_zero  = (top == 4'd0);
  assign sts_o.out_free  = out_free;

  assign out_o.valid    = ov_q;
  assign out_o.out_char = oc_q;
  assign out_o.out_last = ol_q;

endmodule

>>> hw/rtl/hex_decimal_token_converter_unit.sv
// channel  dir  beat payload                 role
// in_i     in   ch[7:0], token_end           token characters, one per beat
// out_o    out  out_char[7:0], out_last      converted number, one char per beat
//
// A character that does not end a token is taken and in_i stays ready.
// Decimal token end: set-up, "0x", zero skip and hex digits.
// Hex token end: set-up, VALUE_BITS double dabble steps, zero skip and decimal
// digits, at most NDIG of them (NDIG = 10 at 32 bits).
// Reset clears the token state and the stop flag; a stalled out_o holds the
// digit sequencer, and in_i is not ready until the last beat is loaded.
module hex_decimal_token_converter_unit #(
  parameter int VALUE_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hdtc_in_if.sink    in_i,
  hdtc_out_if.source out_o
);
  import hdtc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  hdtc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hdtc_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ch_i        (in_i.ch),
    .token_end_i (in_i.token_end),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_o       (out_o)
  );

endmodule

>>> sim/tb_hex_decimal_token_converter_unit.sv
class conv_scoreboard;
  logic [63:0]    value_max;
  logic [63:0]    value;
  hdtc_pkg::pos_e pos;
  bit             hex_mode;
  bit             halted;
  logic [8:0]     pending_chars[$];
  int unsigned    errors;

  function new(int unsigned value_bits);
    value_max = {64{1'b1}} >> (64 - value_bits);
    value     = '0;
    pos       = hdtc_pkg::POS_START;
    hex_mode  = 1'b0;
    halted    = 1'b0;
    errors    = 0;
  endfunction

  function int unsigned digit_value(logic [7:0] ch, bit hex);
    if (ch >= hdtc_pkg::CH_ZERO && ch <= hdtc_pkg::CH_NINE)
      return 32'(ch - hdtc_pkg::CH_ZERO);
    if (hex && ch >= hdtc_pkg::CH_UP_A && ch <= hdtc_pkg::CH_UP_F)
      return ch - hdtc_pkg::CH_UP_A + 10;
    if (hex && ch >= hdtc_pkg::CH_LO_A && ch <= hdtc_pkg::CH_LO_F)
      return ch - hdtc_pkg::CH_LO_A + 10;
    return 0;
  endfunction

  // saturating multiply-accumulate of one digit
  function void push(logic [7:0] ch, bit hex);
    logic [63:0] d;
    logic [63:0] base;
    base = hex ? 64'd16 : 64'd10;
    d    = 64'(digit_value(ch, hex));
    if (value > (value_max - d) / base) value = value_max;
    else value = value * base + d;
  endfunction

  function void take_char(logic [7:0] ch, logic tok_end);
    logic [63:0] v;
    logic [7:0]  text[$];
    logic [3:0]  nib;
    if (halted) return;
    case (pos)
      hdtc_pkg::POS_START: begin
        if (ch == hdtc_pkg::CH_MINUS) begin
          halted   = 1'b1;
          value    = '0;
          hex_mode = 1'b0;
          return;
        end
        value = 64'(digit_value(ch, 1'b0));
        pos   = (ch == hdtc_pkg::CH_ZERO) ? hdtc_pkg::POS_ZERO : hdtc_pkg::POS_BODY;
      end
      hdtc_pkg::POS_ZERO: begin
        if (ch == hdtc_pkg::CH_LO_X) begin
          hex_mode = 1'b1;
          value    = '0;
        end else begin
          push(ch, 1'b0);
        end
        pos = hdtc_pkg::POS_BODY;
      end
      default: push(ch, hex_mode);
    endcase
    if (!tok_end) return;
    v = value & value_max;
    if (hex_mode) begin
      do begin
        text.push_front(hdtc_pkg::CH_ZERO + 8'(v % 64'd10));
        v = v / 64'd10;
      end while (v != 0);
    end else begin
      do begin
        nib = v[3:0];
        text.push_front(nib < 4'd10 ? hdtc_pkg::CH_ZERO + 8'(nib)
                                    : hdtc_pkg::CH_UP_A + 8'(nib) - 8'd10);
        v = v >> 4;
      end while (v != 0);
      text.push_front(hdtc_pkg::CH_LO_X);
      text.push_front(hdtc_pkg::CH_ZERO);
    end
    foreach (text[i]) pending_chars.push_back({i == text.size() - 1, text[i]});
    value    = '0;
    pos      = hdtc_pkg::POS_START;
    hex_mode = 1'b0;
  endfunction

  function void check_char(logic [7:0] c, logic last);
    logic [8:0] want;
    if (pending_chars.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected output beat: char %h last %b", c, last);
      return;
    end
    want = pending_chars.pop_front();
    if (want !== {last, c}) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: expected char %h last %b, got char %h last %b",
                 want[7:0], want[8], c, last);
    end
  endfunction
endclass

module tb_hex_decimal_token_converter_unit;
  import hdtc_pkg::*;

  localparam int VALUE_BITS   = 32;
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_ITEMS = 470;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int unsigned    send_idle_pct;
  int unsigned    recv_idle_pct;
  int unsigned    items_sent;
  logic [7:0]     token_buf[$];
  conv_scoreboard sb;

  hdtc_in_if  in_if ();
  hdtc_out_if out_if ();

  hex_decimal_token_converter_unit #(
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) sb.take_char(in_if.ch, in_if.token_end);
      if (out_if.valid && out_if.ready) sb.check_char(out_if.out_char, out_if.out_last);
    end
  end

  initial begin
    #800000;
    $display("tb_hex_decimal_token_converter_unit: done, errors");
    $finish;
  end

  task automatic send_char(input logic [7:0] ch, input logic tok_end);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid     = 1'b1;
    in_if.ch        = ch;
    in_if.token_end = tok_end;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic send_token_buf();
    foreach (token_buf[i]) send_char(token_buf[i], i == token_buf.size() - 1);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (sb.pending_chars.size() != 0) @(posedge clk_i);
  endtask

  function automatic void build_random_token();
    int unsigned kind;
    int unsigned len;
    int unsigned d;
    token_buf.delete();
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 13) : $urandom_range(1, 6);
      repeat (len) token_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    end else if (kind < 80) begin
      token_buf.push_back(CH_ZERO);
      token_buf.push_back(CH_LO_X);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 10) : $urandom_range(0, 5);
      repeat (len) begin
        d = $urandom_range(0, 15);
        if (d < 10) token_buf.push_back(CH_ZERO + 8'(d));
        else if ($urandom_range(0, 1)) token_buf.push_back(CH_UP_A + 8'(d - 10));
        else token_buf.push_back(CH_LO_A + 8'(d - 10));
      end
    end else if (kind < 92) begin
      len = $urandom_range(1, 6);
      repeat (len) token_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      token_buf.push_back(CH_ZERO);
      if ($urandom_range(0, 1)) token_buf.push_back(8'($urandom_range(0, 255)));
    end
    // occasional corrupted character in an otherwise well-formed number
    if (kind < 80 && $urandom_range(0, 7) == 0)
      token_buf[$urandom_range(0, token_buf.size() - 1)] = 8'($urandom_range(0, 255));
    // a leading minus would stop the block; kept for the end of the run
    if (token_buf[0] == CH_MINUS) token_buf[0] = CH_ZERO;
  endfunction

  initial begin
    int unsigned phase;
    in_if.valid     = 1'b0;
    in_if.ch        = '0;
    in_if.token_end = 1'b0;
    sb              = new(VALUE_BITS);
    send_idle_pct   = 13;
    recv_idle_pct   = 86;
    items_sent      = 0;
    phase           = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_text("0");
    send_text("0x");
    send_text("0xfFfFfFfFf");
    send_text("7X-");
    send_text("0X1");
    send_char(8'hFF, 1'b1);
    send_char(8'h80, 1'b1);

    while (items_sent < RANDOM_ITEMS) begin
      build_random_token();
      send_token_buf();
      if (phase == 0 && items_sent >= 180) begin
        wait_drained();
        send_idle_pct = 86;
        recv_idle_pct = 13;
        phase         = 1;
      end else if (phase == 1 && items_sent >= 340) begin
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        phase         = 2;
      end
    end

    // minus token: everything after it is swallowed
    send_text("-12");
    send_text("0x5");
    send_char(CH_ZERO, 1'b1);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_chars.size() == 0) begin
      $display("tb_hex_decimal_token_converter_unit: done, clean");
    end else begin
      $display("tb_hex_decimal_token_converter_unit: done, errors");
    end
    $finish;
  end
endmodule
